// ===== rtl/jwt_pkg.sv =====
`default_nettype none
package jwt_pkg;
   localparam int MaxJoints = 256;
   localparam int FracBits = 16;
   localparam int JointW = 8;
   localparam int CntW = 9;
   localparam int WordW = 32;
   localparam int ProdW = 64;
   localparam int SumW = 66;
   localparam logic [CntW-1:0] ActiveReset = 9'd256;

   typedef logic signed [WordW-1:0] word_type;
   typedef word_type [3:0] row_type;

   // rounded and saturated Q16.16 of an exact sum of four products
   function automatic word_type round_sat(input logic signed [SumW-1:0] s);
      logic signed [SumW-1:0] t;
      logic signed [SumW-1:0] v;
      t = s + (SumW'(1) <<< (FracBits - 1));
      v = t >>> FracBits;
      if (v > SumW'(signed'(32'sh7fffffff)))
         round_sat = 32'sh7fffffff;
      else if (v < -SumW'(64'sh80000000))
         round_sat = 32'sh80000000;
      else
         round_sat = v[WordW-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/jwt_if.sv =====
`default_nettype none
interface jwt_req_if;
   logic valid;
   logic ready;
   logic [7:0] joint;
   logic [7:0] parent;
   logic has_parent;
   logic [1:0] row;
   logic signed [31:0] m0, m1, m2, m3;
   modport source (output valid, joint, parent, has_parent, row, m0, m1, m2, m3, input ready);
   modport sink (input valid, joint, parent, has_parent, row, m0, m1, m2, m3, output ready);
endinterface

interface jwt_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_joint;
   logic [1:0] out_row;
   logic signed [31:0] w0, w1, w2, w3;
   logic last;
   modport source (output valid, out_joint, out_row, w0, w1, w2, w3, last, input ready);
   modport sink (input valid, out_joint, out_row, w0, w1, w2, w3, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/joint_world_transform.sv =====
`default_nettype none
// Forward-kinematics stage. Input words on req carry one row of a joint's
// local 4x4 Q16.16 transform. Rows 0..2 are buffered; row 3 starts the
// world-matrix job: W = P * L with P the parent's stored world when
// has_parent is set and parent < count, else W = L. Joints at or above the
// count (min of csr_active_joints and 256) are dropped.
// A job emits four words on rsp, row 3 marked last.
// Throughput: a job issues its four world rows to the four-lane multiplier,
// one per cycle while the pipeline advances, each parent row read from the
// world memory. Row 0..2 words are taken each cycle outside the clearing
// pass, also while a job runs; a row 3 word waits until the previous job's
// rows have all been issued. One word per cycle sustained unless rsp stalls.
// The world memory (256 x 16 words, 1024 entries of one row) is cleared after
// reset by a pass over all entries, one entry per cycle, in which req is held
// not ready. csr writes are taken any time.
// A stalled rsp backs up through a 2-entry skid buffer into the pipeline.
module joint_world_transform (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [8:0] csr_data,
   jwt_req_if.sink req,
   jwt_rsp_if.source rsp
);
   localparam int AW = $clog2(jwt_pkg::MaxJoints);
   localparam int CW = AW + 2;

   logic [jwt_pkg::CntW-1:0] active_ff;
   logic [jwt_pkg::CntW-1:0] count;
   jwt_pkg::row_type loc_ff [3];
   jwt_pkg::row_type world_mem [jwt_pkg::MaxJoints*4];
   logic clr_ff;
   logic [CW-1:0] clr_idx_ff;

   // job registers (stage 0)
   logic job_ff;
   logic [1:0] jrow_ff;
   logic [7:0] jjoint_ff;
   logic [AW-1:0] jpar_ff;
   logic juse_ff;
   jwt_pkg::row_type jl_ff [4];

   // stage 1: parent row read
   logic s1_ff, s1use_ff, s1last_ff;
   logic [1:0] s1row_ff;
   logic [7:0] s1joint_ff;
   jwt_pkg::row_type prow_ff;
   jwt_pkg::row_type s1m_ff [4];
   // stage 2: products
   logic s2_ff, s2use_ff;
   logic [1:0] s2row_ff;
   logic [7:0] s2joint_ff;
   jwt_pkg::row_type s2l_ff;

   logic adv, accept, start;
   logic [1:0] skid_cnt_ff;
   jwt_pkg::row_type col [4];
   jwt_pkg::row_type lrow;
   jwt_pkg::word_type lane_out [4];
   jwt_pkg::row_type wrow;

   // skid fifo
   logic [7:0] fj_ff [2];
   logic [1:0] fr_ff [2];
   jwt_pkg::row_type fw_ff [2];
   logic rd_ff, wr_ff;

   assign count = (active_ff > jwt_pkg::CntW'(jwt_pkg::MaxJoints))
                  ? jwt_pkg::CntW'(jwt_pkg::MaxJoints) : active_ff;
   // pipeline moves while the skid has a free entry
   assign adv = skid_cnt_ff != 2'd2;
   assign req.ready = !clr_ff && (!job_ff || (jrow_ff == 2'd3 && adv) || req.row != 2'd3);
   assign accept = req.valid && req.ready;
   assign start = accept && req.row == 2'd3 && {1'b0, req.joint} < count;

   always_ff @(posedge clock) begin
      if (reset) active_ff <= jwt_pkg::ActiveReset;
      else if (csr_write) active_ff <= csr_data;
   end

   // local row buffer
   always_ff @(posedge clock) begin
      if (accept && req.row != 2'd3)
         loc_ff[req.row] <= '{req.m3, req.m2, req.m1, req.m0};
   end

   // job sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= 1'b0;
         jrow_ff <= 2'd0;
      end else if (start) begin
         job_ff <= 1'b1;
         jrow_ff <= 2'd0;
      end else if (job_ff && adv) begin
         if (jrow_ff == 2'd3) job_ff <= 1'b0;
         jrow_ff <= jrow_ff + 2'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (start) begin
         jjoint_ff <= req.joint;
         jpar_ff <= AW'(req.parent);
         juse_ff <= req.has_parent && {1'b0, req.parent} < count;
         jl_ff[0] <= loc_ff[0];
         jl_ff[1] <= loc_ff[1];
         jl_ff[2] <= loc_ff[2];
         jl_ff[3] <= '{req.m3, req.m2, req.m1, req.m0};
      end
   end

   // world memory: parent read, world write, clearing pass
   always_ff @(posedge clock) begin
      if (job_ff && adv) prow_ff <= world_mem[{jpar_ff, jrow_ff}];
      if (clr_ff) begin
         world_mem[clr_idx_ff] <= '0;
      end else if (s2_ff && adv) begin
         world_mem[{AW'(s2joint_ff), s2row_ff}] <= wrow;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + CW'(1);
         if (clr_idx_ff == CW'(jwt_pkg::MaxJoints*4 - 1)) clr_ff <= 1'b0;
      end
   end

   // pipeline stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else if (adv) begin
         s1_ff <= job_ff;
         s2_ff <= s1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1use_ff <= juse_ff;
         s1row_ff <= jrow_ff;
         s1joint_ff <= jjoint_ff;
         s1last_ff <= jrow_ff == 2'd3;
         s1m_ff <= jl_ff;
         s2use_ff <= s1use_ff;
         s2row_ff <= s1row_ff;
         s2joint_ff <= s1joint_ff;
         s2l_ff <= lrow;
      end
   end

   // columns of the local matrix and the pass-through row, from the stage 1 copy
   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 4; k++) col[c][k] = s1m_ff[k][c];
      lrow = s1m_ff[s1row_ff];
   end

   // four lanes, one per world column
   for (genvar c = 0; c < 4; c++) begin : g_lane
      jwt_lane u_lane (
         .clock (clock),
         .enable(adv),
         .prow  (prow_ff),
         .col   (col[c]),
         .result(lane_out[c])
      );
   end

   always_comb begin
      for (int c = 0; c < 4; c++) wrow[c] = s2use_ff ? lane_out[c] : s2l_ff[c];
   end

   // output skid fifo
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         skid_cnt_ff <= skid_cnt_ff + 2'(s2_ff && adv) - 2'(rsp.valid && rsp.ready);
         if (s2_ff && adv) wr_ff <= !wr_ff;
         if (rsp.valid && rsp.ready) rd_ff <= !rd_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (s2_ff && adv) begin
         fj_ff[wr_ff] <= s2joint_ff;
         fr_ff[wr_ff] <= s2row_ff;
         fw_ff[wr_ff] <= wrow;
      end
   end
   assign rsp.valid = skid_cnt_ff != 2'd0;
   assign rsp.out_joint = fj_ff[rd_ff];
   assign rsp.out_row = fr_ff[rd_ff];
   assign rsp.w0 = fw_ff[rd_ff][0];
   assign rsp.w1 = fw_ff[rd_ff][1];
   assign rsp.w2 = fw_ff[rd_ff][2];
   assign rsp.w3 = fw_ff[rd_ff][3];
   assign rsp.last = fr_ff[rd_ff] == 2'd3;

   a_skid: assert property (@(posedge clock) disable iff (reset) skid_cnt_ff <= 2'd2)
      else $error("skid overflow");
   a_clr: assert property (@(posedge clock) disable iff (reset) clr_ff |-> !req.ready)
      else $error("accept during clear");
   a_s1: assert property (@(posedge clock) disable iff (reset) s1_ff && adv && s1last_ff |=> !s1_ff || s1row_ff == 2'd0)
      else $error("row order");
endmodule
`default_nettype wire

// ===== rtl/jwt_lane.sv =====
`default_nettype none
// one output column: four products registered, then summed and rounded
module jwt_lane (
   input  wire logic clock,
   input  wire logic enable,
   input  wire jwt_pkg::row_type prow,
   input  wire jwt_pkg::row_type col,
   output jwt_pkg::word_type result
);
   logic signed [jwt_pkg::ProdW-1:0] prod_ff [4];
   logic signed [jwt_pkg::SumW-1:0] sum;

   // products
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) prod_ff[k] <= prow[k] * col[k];
      end
   end

   // merge and round
   always_comb begin
      sum = jwt_pkg::SumW'(prod_ff[0]) + jwt_pkg::SumW'(prod_ff[1])
          + jwt_pkg::SumW'(prod_ff[2]) + jwt_pkg::SumW'(prod_ff[3]);
      result = jwt_pkg::round_sat(sum);
   end
endmodule
`default_nettype wire
